/* rtl/core/mjs_pkg.sv */
// Shared types, codes and the ordering function of the job scheduler.
`default_nettype none
package mjs_pkg;

    localparam int NUM_CORES_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 64;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORES  = 1'b1;

    localparam logic [2:0] SCH_FCFS = 3'd0;
    localparam logic [2:0] SCH_SJF  = 3'd1;
    localparam logic [2:0] SCH_PSJF = 3'd2;
    localparam logic [2:0] SCH_PRI  = 3'd3;
    localparam logic [2:0] SCH_PPRI = 3'd4;
    localparam logic [2:0] SCH_RR   = 3'd5;

    localparam logic [1:0] MODE_ARRIVE = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_EXPIRE = 2'd2;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] length;
        logic [15:0] left;
        logic [15:0] urgency;
        logic [31:0] arrival;
        logic [31:0] first;
        logic        started;
    } task_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_AGE,
        OP_STAMP,
        OP_KCLR,
        OP_KINC,
        OP_PLACE_IDLE,
        OP_PREEMPT,
        OP_OVF,
        OP_INS_NEW,
        OP_INS_CI,
        OP_QPTR0,
        OP_QRD,
        OP_QINC,
        OP_SPTR_CNT,
        OP_SRD,
        OP_SWR,
        OP_INS_WR,
        OP_HOLD,
        OP_PWR,
        OP_POP_END,
        OP_MEAS,
        OP_ACCUM,
        OP_KEEP,
        OP_DISPATCH,
        OP_DONE
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AGE,
        ST_BRANCH,
        ST_PSCAN,
        ST_ARR_QUEUE,
        ST_INS_START,
        ST_IS_RD,
        ST_IS_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_EXP_RD,
        ST_EXP_CMP,
        ST_POP_RD,
        ST_POP_HEAD,
        ST_POP_LOOP,
        ST_POP_WR,
        ST_RETIRE,
        ST_ACCUM,
        ST_FIN_POP,
        ST_DISPATCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       ci_ok;
        logic       core_busy;
        logic       k_end;
        logic       idle_found;
        logic       preemptive;
        logic       pre_hit;
        logic       q_full;
        logic       q_empty;
        logic       qscan_end;
        logic       shift_end;
        logic       ins_hit;
        logic       keep_hit;
    } stat_t;

    // true when a goes strictly ahead of b under the given scheme
    function automatic logic precedes(logic [2:0] scheme, task_t a, task_t b);
        logic r;
        case (scheme) inside
            SCH_SJF, SCH_PSJF:
                r = (a.left != b.left) ? (a.left < b.left) : (a.arrival < b.arrival);
            SCH_PRI, SCH_PPRI:
                r = (a.urgency != b.urgency) ? (a.urgency < b.urgency)
                                             : (a.arrival < b.arrival);
            SCH_RR:
                r = 1'b0;
            default:
                r = a.arrival < b.arrival;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/multicore_job_scheduler.sv */
// Multicore job scheduler top level.
//
// Command interface: an event beat (mode, job_id, now, run_length, priority_req,
// core_index) is taken at a rising edge with start high and busy low. busy stays
// high while the event is worked on. The result beat (scheduled, target_core,
// placed_job, queue_overflow and the running totals) shows for exactly one
// cycle with done high; the receiver cannot stall it.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 scheme, 1
// cores_in_use) at the edge. User writes only while busy is low; not enforced.
// Sequence: the first walk ages every active core, one core a cycle. An arrival
// is then placed on an idle core if one is free. A queue insert scans the ready
// queue and shifts the tail entry by entry through the single queue memory port;
// a pop shifts the whole queue the same way. One event is handled at a time.
// Reset: all cores idle, queue empty, time and totals zero, scheme FCFS with one
// core. Queue and core records need no clearing; only valid entries are read.
`default_nettype none
module multicore_job_scheduler #(
    parameter int NUM_CORES   = mjs_pkg::NUM_CORES_DEF,
    parameter int QUEUE_DEPTH = mjs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    output logic                                done,
    input  wire logic                           cfg_we,
    input  wire logic [mjs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mjs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [1:0]                     mode,
    input  wire logic [15:0]                    job_id,
    input  wire logic [31:0]                    now,
    input  wire logic [15:0]                    run_length,
    input  wire logic [15:0]                    priority_req,
    input  wire logic [2:0]                     core_index,
    output logic                                scheduled,
    output logic [2:0]                          target_core,
    output logic [15:0]                         placed_job,
    output logic                                queue_overflow,
    output logic [31:0]                         jobs_done,
    output logic [47:0]                         total_wait,
    output logic [47:0]                         total_turnaround,
    output logic [47:0]                         total_response
);
    import mjs_pkg::*;

    op_t   op;
    stat_t stat;

    mjs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .op    (op),
        .busy  (busy)
    );

    mjs_datapath #(
        .NUM_CORES   (NUM_CORES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mode             (mode),
        .job_id           (job_id),
        .now              (now),
        .run_length       (run_length),
        .priority_req     (priority_req),
        .core_index       (core_index),
        .op               (op),
        .stat             (stat),
        .done             (done),
        .scheduled        (scheduled),
        .target_core      (target_core),
        .placed_job       (placed_job),
        .queue_overflow   (queue_overflow),
        .jobs_done        (jobs_done),
        .total_wait       (total_wait),
        .total_turnaround (total_turnaround),
        .total_response   (total_response)
    );

endmodule
`default_nettype wire

/* rtl/core/mjs_datapath.sv */
// Scheduler datapath: core table, ready queue memory, sums and result registers.
`default_nettype none
module mjs_datapath #(
    parameter int NUM_CORES   = mjs_pkg::NUM_CORES_DEF,
    parameter int QUEUE_DEPTH = mjs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mjs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mjs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [1:0]                        mode,
    input  wire logic [15:0]                       job_id,
    input  wire logic [31:0]                       now,
    input  wire logic [15:0]                       run_length,
    input  wire logic [15:0]                       priority_req,
    input  wire logic [2:0]                        core_index,
    input  wire mjs_pkg::op_t                      op,
    output mjs_pkg::stat_t                         stat,
    output logic                                   done,
    output logic                                   scheduled,
    output logic [2:0]                             target_core,
    output logic [15:0]                            placed_job,
    output logic                                   queue_overflow,
    output logic [31:0]                            jobs_done,
    output logic [47:0]                            total_wait,
    output logic [47:0]                            total_turnaround,
    output logic [47:0]                            total_response
);
    import mjs_pkg::*;

    localparam int CIW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int NW  = $clog2(NUM_CORES + 1);
    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    // configuration
    logic [2:0]            scheme_reg;
    logic [3:0]            cores_in_use_reg;

    // latched event
    logic [1:0]            mode_reg;
    logic [15:0]           job_id_reg;
    logic [31:0]           now_reg;
    logic [15:0]           run_length_reg;
    logic [15:0]           priority_reg;
    logic [2:0]            core_index_reg;
    logic [31:0]           elapsed_reg;

    // cores
    task_t                 cores_reg [NUM_CORES];
    logic [NUM_CORES-1:0]  busy_reg;
    logic [NW-1:0]         kidx_reg;

    // ready queue
    task_t                 mem [QUEUE_DEPTH];
    task_t                 rdata_reg;
    logic [QCW-1:0]        qcount_reg;
    logic [QCW-1:0]        qptr_reg;
    logic [QCW-1:0]        sptr_reg;
    task_t                 ins_reg;
    task_t                 hold_reg;

    // bookkeeping
    logic [31:0]           last_time_reg;
    logic [31:0]           turn_reg;
    logic [31:0]           resp_reg;
    logic [47:0]           wait_sum_reg;
    logic [47:0]           turn_sum_reg;
    logic [47:0]           resp_sum_reg;
    logic [31:0]           finished_reg;

    logic                  done_reg;
    logic                  sched_reg;
    logic [2:0]            tcore_reg;
    logic [15:0]           pjob_reg;
    logic                  ovf_reg;

    // combinational
    logic [NW-1:0]         n_active;
    logic [CIW-1:0]        kaddr;
    logic [CIW-1:0]        idle_idx;
    logic                  idle_found;
    task_t                 cur;
    task_t                 new_task;
    task_t                 hold_fix;
    logic [15:0]           aged_left;
    logic [31:0]           wait_val;
    logic [QCW-1:0]        qptr_m1;
    logic [QCW-1:0]        sptr_m1;
    logic                  mem_we;
    logic [QAW-1:0]        waddr;
    task_t                 wdata;
    logic                  mem_re;
    logic [QAW-1:0]        raddr;

    always_comb
    begin
        if (cores_in_use_reg == 4'd0)
        begin
            n_active = NW'(1);
        end
        else if (int'(cores_in_use_reg) > NUM_CORES)
        begin
            n_active = NW'(NUM_CORES);
        end
        else
        begin
            n_active = NW'(cores_in_use_reg);
        end
    end

    assign kaddr = kidx_reg[CIW-1:0];
    assign cur   = cores_reg[kaddr];

    always_comb
    begin
        idle_found = 1'b0;
        idle_idx   = '0;
        for (int i = NUM_CORES - 1; i >= 0; i--)
        begin
            if (i < int'(n_active) && !busy_reg[i])
            begin
                idle_found = 1'b1;
                idle_idx   = CIW'(i);
            end
        end
    end

    always_comb
    begin
        new_task.id      = job_id_reg;
        new_task.length  = run_length_reg;
        new_task.left    = run_length_reg;
        new_task.urgency = priority_reg;
        new_task.arrival = now_reg;
        new_task.first   = now_reg;
        new_task.started = 1'b1;

        hold_fix = hold_reg;
        if (!hold_reg.started)
        begin
            hold_fix.first   = now_reg;
            hold_fix.started = 1'b1;
        end
    end

    assign aged_left = ({16'd0, cur.left} > elapsed_reg) ? (cur.left - elapsed_reg[15:0])
                                                         : 16'd0;
    assign wait_val  = (turn_reg >= {16'd0, cur.length}) ? (turn_reg - {16'd0, cur.length})
                                                         : 32'd0;
    assign qptr_m1   = qptr_reg - QCW'(1);
    assign sptr_m1   = sptr_reg - QCW'(1);

    always_comb
    begin
        stat.mode       = mode_reg;
        stat.ci_ok      = int'(core_index_reg) < int'(n_active);
        stat.core_busy  = busy_reg[kaddr];
        stat.k_end      = kidx_reg >= n_active;
        stat.idle_found = idle_found;
        stat.preemptive = (scheme_reg == SCH_PSJF) || (scheme_reg == SCH_PPRI);
        stat.pre_hit    = busy_reg[kaddr] && precedes(scheme_reg, new_task, cur);
        stat.q_full     = qcount_reg == QCW'(QUEUE_DEPTH);
        stat.q_empty    = qcount_reg == '0;
        stat.qscan_end  = qptr_reg >= qcount_reg;
        stat.shift_end  = sptr_reg == qptr_reg;
        stat.ins_hit    = precedes(scheme_reg, ins_reg, rdata_reg);
        stat.keep_hit   = precedes(scheme_reg, cur, rdata_reg);
    end

    // queue memory port control
    always_comb
    begin
        mem_we = 1'b0;
        waddr  = sptr_reg[QAW-1:0];
        wdata  = rdata_reg;
        mem_re = 1'b0;
        raddr  = qptr_reg[QAW-1:0];
        case (op)
            OP_QRD:
            begin
                mem_re = 1'b1;
            end
            OP_SRD:
            begin
                mem_re = 1'b1;
                raddr  = sptr_m1[QAW-1:0];
            end
            OP_SWR:
            begin
                mem_we = 1'b1;
            end
            OP_INS_WR:
            begin
                mem_we = 1'b1;
                wdata  = ins_reg;
            end
            OP_PWR:
            begin
                mem_we = 1'b1;
                waddr  = qptr_m1[QAW-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                mode_reg       <= mode;
                job_id_reg     <= job_id;
                now_reg        <= now;
                run_length_reg <= run_length;
                priority_reg   <= priority_req;
                core_index_reg <= core_index;
                elapsed_reg    <= (now >= last_time_reg) ? (now - last_time_reg) : 32'd0;
            end
            OP_AGE:
            begin
                if (!stat.k_end && busy_reg[kaddr])
                begin
                    cores_reg[kaddr].left <= aged_left;
                end
            end
            OP_PLACE_IDLE:
            begin
                cores_reg[idle_idx] <= new_task;
            end
            OP_PREEMPT:
            begin
                ins_reg          <= cur;
                cores_reg[kaddr] <= new_task;
            end
            OP_INS_NEW:
            begin
                // a queued arrival has not started yet
                ins_reg <= {new_task.id, new_task.length, new_task.left, new_task.urgency,
                            new_task.arrival, 32'd0, 1'b0};
            end
            OP_INS_CI:
            begin
                ins_reg <= cur;
            end
            OP_HOLD:
            begin
                hold_reg <= rdata_reg;
            end
            OP_MEAS:
            begin
                turn_reg <= now_reg - cur.arrival;
                resp_reg <= cur.first - cur.arrival;
            end
            OP_DISPATCH:
            begin
                cores_reg[kaddr] <= hold_fix;
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg       <= SCH_FCFS;
            cores_in_use_reg <= 4'd1;
            busy_reg         <= '0;
            kidx_reg         <= '0;
            qcount_reg       <= '0;
            qptr_reg         <= '0;
            sptr_reg         <= '0;
            last_time_reg    <= '0;
            wait_sum_reg     <= '0;
            turn_sum_reg     <= '0;
            resp_sum_reg     <= '0;
            finished_reg     <= '0;
            done_reg         <= 1'b0;
            sched_reg        <= 1'b0;
            tcore_reg        <= '0;
            pjob_reg         <= '0;
            ovf_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SCHEME: scheme_reg       <= cfg_data[2:0];
                    CFG_CORES:  cores_in_use_reg <= cfg_data;
                    default:    scheme_reg       <= scheme_reg;
                endcase
            end
            done_reg <= op == OP_DONE;
            case (op)
                OP_LOAD:
                begin
                    kidx_reg  <= '0;
                    sched_reg <= 1'b0;
                    tcore_reg <= '0;
                    pjob_reg  <= '0;
                    ovf_reg   <= 1'b0;
                end
                OP_AGE, OP_KINC:
                begin
                    kidx_reg <= kidx_reg + NW'(1);
                end
                OP_STAMP:
                begin
                    last_time_reg <= now_reg;
                    kidx_reg      <= NW'(core_index_reg);
                end
                OP_KCLR:
                begin
                    kidx_reg <= '0;
                end
                OP_PLACE_IDLE:
                begin
                    busy_reg[idle_idx] <= 1'b1;
                    sched_reg          <= 1'b1;
                    tcore_reg          <= 3'(idle_idx);
                    pjob_reg           <= job_id_reg;
                end
                OP_PREEMPT:
                begin
                    sched_reg <= 1'b1;
                    tcore_reg <= 3'(kidx_reg);
                    pjob_reg  <= job_id_reg;
                end
                OP_OVF:
                begin
                    ovf_reg <= 1'b1;
                end
                OP_QPTR0, OP_INS_CI:
                begin
                    qptr_reg <= '0;
                end
                OP_QINC:
                begin
                    qptr_reg <= qptr_reg + QCW'(1);
                end
                OP_SPTR_CNT:
                begin
                    sptr_reg <= qcount_reg;
                end
                OP_SWR:
                begin
                    sptr_reg <= sptr_m1;
                end
                OP_INS_WR:
                begin
                    qcount_reg <= qcount_reg + QCW'(1);
                end
                OP_HOLD:
                begin
                    qptr_reg <= QCW'(1);
                end
                OP_PWR:
                begin
                    qptr_reg <= qptr_reg + QCW'(1);
                end
                OP_POP_END:
                begin
                    qcount_reg <= qcount_reg - QCW'(1);
                end
                OP_ACCUM:
                begin
                    wait_sum_reg    <= wait_sum_reg + {16'd0, wait_val};
                    turn_sum_reg    <= turn_sum_reg + {16'd0, turn_reg};
                    resp_sum_reg    <= resp_sum_reg + {16'd0, resp_reg};
                    finished_reg    <= finished_reg + 32'd1;
                    busy_reg[kaddr] <= 1'b0;
                end
                OP_KEEP:
                begin
                    sched_reg <= 1'b1;
                    tcore_reg <= 3'(kidx_reg);
                    pjob_reg  <= cur.id;
                end
                OP_DISPATCH:
                begin
                    busy_reg[kaddr] <= 1'b1;
                    sched_reg       <= 1'b1;
                    tcore_reg       <= 3'(kidx_reg);
                    pjob_reg        <= hold_reg.id;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign done             = done_reg;
    assign scheduled        = sched_reg;
    assign target_core      = tcore_reg;
    assign placed_job       = pjob_reg;
    assign queue_overflow   = ovf_reg;
    assign jobs_done        = finished_reg;
    assign total_wait       = wait_sum_reg;
    assign total_turnaround = turn_sum_reg;
    assign total_response   = resp_sum_reg;

endmodule
`default_nettype wire

/* rtl/core/mjs_ctrl.sv */
// Scheduler controller: sequences aging, placement, queue insert and pop.
`default_nettype none
module mjs_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire mjs_pkg::stat_t stat,
    output mjs_pkg::op_t        op,
    output logic                busy
);
    import mjs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LOAD;
                    state_next = ST_AGE;
                end
            end
            ST_AGE:
            begin
                if (stat.k_end)
                begin
                    op         = OP_STAMP;
                    state_next = ST_BRANCH;
                end
                else
                begin
                    op = OP_AGE;
                end
            end
            ST_BRANCH:
            begin
                if (stat.mode == MODE_ARRIVE)
                begin
                    if (stat.idle_found)
                    begin
                        op         = OP_PLACE_IDLE;
                        state_next = ST_DONE;
                    end
                    else if (stat.preemptive)
                    begin
                        op         = OP_KCLR;
                        state_next = ST_PSCAN;
                    end
                    else
                    begin
                        state_next = ST_ARR_QUEUE;
                    end
                end
                else if (stat.mode == MODE_FINISH && stat.ci_ok)
                begin
                    state_next = ST_RETIRE;
                end
                else if (stat.mode == MODE_EXPIRE && stat.ci_ok && stat.core_busy)
                begin
                    if (stat.q_empty)
                    begin
                        op         = OP_KEEP;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        op         = OP_QPTR0;
                        state_next = ST_EXP_RD;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_PSCAN:
            begin
                if (stat.k_end)
                begin
                    state_next = ST_ARR_QUEUE;
                end
                else if (stat.pre_hit)
                begin
                    if (stat.q_full)
                    begin
                        op         = OP_OVF;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        op         = OP_PREEMPT;
                        state_next = ST_INS_START;
                    end
                end
                else
                begin
                    op = OP_KINC;
                end
            end
            ST_ARR_QUEUE:
            begin
                if (stat.q_full)
                begin
                    op         = OP_OVF;
                    state_next = ST_DONE;
                end
                else
                begin
                    op         = OP_INS_NEW;
                    state_next = ST_INS_START;
                end
            end
            ST_INS_START:
            begin
                // on expiry the running job is copied into the insert slot here
                op         = (stat.mode == MODE_EXPIRE) ? OP_INS_CI : OP_QPTR0;
                state_next = ST_IS_RD;
            end
            ST_IS_RD:
            begin
                if (stat.qscan_end)
                begin
                    op         = OP_SPTR_CNT;
                    state_next = ST_SH_RD;
                end
                else
                begin
                    op         = OP_QRD;
                    state_next = ST_IS_CMP;
                end
            end
            ST_IS_CMP:
            begin
                if (stat.ins_hit)
                begin
                    op         = OP_SPTR_CNT;
                    state_next = ST_SH_RD;
                end
                else
                begin
                    op         = OP_QINC;
                    state_next = ST_IS_RD;
                end
            end
            ST_SH_RD:
            begin
                if (stat.shift_end)
                begin
                    op         = OP_INS_WR;
                    state_next = (stat.mode == MODE_EXPIRE) ? ST_DISPATCH : ST_DONE;
                end
                else
                begin
                    op         = OP_SRD;
                    state_next = ST_SH_WR;
                end
            end
            ST_SH_WR:
            begin
                op         = OP_SWR;
                state_next = ST_SH_RD;
            end
            ST_EXP_RD:
            begin
                op         = OP_QRD;
                state_next = ST_EXP_CMP;
            end
            ST_EXP_CMP:
            begin
                if (stat.keep_hit)
                begin
                    op         = OP_KEEP;
                    state_next = ST_DONE;
                end
                else
                begin
                    op         = OP_QPTR0;
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD:
            begin
                op         = OP_QRD;
                state_next = ST_POP_HEAD;
            end
            ST_POP_HEAD:
            begin
                op         = OP_HOLD;
                state_next = ST_POP_LOOP;
            end
            ST_POP_LOOP:
            begin
                if (stat.qscan_end)
                begin
                    op = OP_POP_END;
                    // expiry requeues the running job before the swap
                    state_next = (stat.mode == MODE_EXPIRE) ? ST_INS_START : ST_DISPATCH;
                end
                else
                begin
                    op         = OP_QRD;
                    state_next = ST_POP_WR;
                end
            end
            ST_POP_WR:
            begin
                op         = OP_PWR;
                state_next = ST_POP_LOOP;
            end
            ST_RETIRE:
            begin
                if (stat.core_busy)
                begin
                    op         = OP_MEAS;
                    state_next = ST_ACCUM;
                end
                else
                begin
                    state_next = ST_FIN_POP;
                end
            end
            ST_ACCUM:
            begin
                op         = OP_ACCUM;
                state_next = ST_FIN_POP;
            end
            ST_FIN_POP:
            begin
                if (stat.q_empty)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    op         = OP_QPTR0;
                    state_next = ST_POP_RD;
                end
            end
            ST_DISPATCH:
            begin
                op         = OP_DISPATCH;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                op         = OP_DONE;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg != ST_IDLE;

endmodule
`default_nettype wire

/* rtl/core/mjs_checker.sv */
// Port-level checks for the job scheduler, bound onto the top level.
`default_nettype none
module mjs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic        scheduled,
    input wire logic [2:0]  target_core,
    input wire logic [15:0] placed_job,
    input wire logic        queue_overflow
);

    // an accepted event keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("event accepted but busy not raised");

    // a result beat only appears once the event is finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while still busy");

    // a dropped arrival places nothing
    a_ovf_nosched: assert property (@(posedge clk) disable iff (!rst_n)
        (done && queue_overflow) |-> !scheduled)
        else $error("overflow beat with a placement");

    // a no-change beat carries zero core and job
    a_nosched_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !scheduled) |-> (target_core == 3'd0 && placed_job == 16'd0))
        else $error("no-change beat with nonzero core or job");

endmodule

bind multicore_job_scheduler mjs_checker u_mjs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .scheduled      (scheduled),
    .target_core    (target_core),
    .placed_job     (placed_job),
    .queue_overflow (queue_overflow)
);
`default_nettype wire

/* tb/sv/tb.sv */
// Testbench for the multicore job scheduler: directed table, then random events.
module tb;
    import mjs_pkg::*;

    typedef struct {
        logic        sched;
        logic [2:0]  core;
        logic [15:0] job;
        logic        ovf;
        logic [31:0] done_cnt;
        logic [47:0] wait_sum;
        logic [47:0] turn_sum;
        logic [47:0] resp_sum;
    } outcome_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  md;
        logic [15:0] id;
        logic [31:0] t;
        logic [15:0] len;
        logic [15:0] pri;
        logic [2:0]  ci;
        bit          typed;
        logic        sched;
        logic [2:0]  core;
        logic [15:0] job;
        logic        ovf;
    } row_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int QDEPTH = QUEUE_DEPTH_DEF;
    localparam logic [1:0] MODE_NOP = 2'd3;

    logic        clk, rst_n, start, cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic [1:0]  mode;
    logic [15:0] job_id, run_length, priority_req;
    logic [31:0] now;
    logic [2:0]  core_index;
    wire         busy, done, scheduled, queue_overflow;
    wire [2:0]   target_core;
    wire [15:0]  placed_job;
    wire [31:0]  jobs_done;
    wire [47:0]  total_wait, total_turnaround, total_response;

    multicore_job_scheduler DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mode(mode), .job_id(job_id), .now(now), .run_length(run_length),
        .priority_req(priority_req), .core_index(core_index),
        .scheduled(scheduled), .target_core(target_core), .placed_job(placed_job),
        .queue_overflow(queue_overflow), .jobs_done(jobs_done),
        .total_wait(total_wait), .total_turnaround(total_turnaround),
        .total_response(total_response)
    );

    // scheduler shadow state
    logic [2:0]  sched_mode;
    logic [3:0]  core_limit;
    task_t       ready_q[$];
    task_t       core_job[NUM_CORES_DEF];
    bit          core_on[NUM_CORES_DEF];
    logic [31:0] last_now;
    logic [47:0] sum_wait, sum_turn, sum_resp;
    logic [31:0] finished;

    outcome_t    pending[$];
    int          errors, events_sent, beats_seen, overflows, preempts, wd_count;
    bit          gaps_on;
    logic [31:0] tnow;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit ahead_of(task_t a, task_t b);
        case (sched_mode)
            SCH_SJF, SCH_PSJF:
                return (a.left != b.left) ? (a.left < b.left) : (a.arrival < b.arrival);
            SCH_PRI, SCH_PPRI:
                return (a.urgency != b.urgency) ? (a.urgency < b.urgency)
                                                : (a.arrival < b.arrival);
            SCH_RR:
                return 1'b0;
            default:
                return a.arrival < b.arrival;
        endcase
    endfunction

    task automatic enqueue_ready(task_t t);
        int pos;
        pos = ready_q.size();
        for (int j = 0; j < ready_q.size(); j++)
            if (ahead_of(t, ready_q[j])) begin
                pos = j;
                break;
            end
        ready_q.insert(pos, t);
    endtask

    task automatic schedule_event(row_t e, output outcome_t o);
        int          n;
        bit          placed;
        logic [31:0] elapsed, turn, wt;
        task_t       t, r;
        n = (core_limit < 1) ? 1 : (core_limit > NUM_CORES_DEF) ? NUM_CORES_DEF : core_limit;
        o = '{default: '0};
        elapsed = (e.t >= last_now) ? e.t - last_now : 32'd0;
        for (int i = 0; i < n; i++)
            if (core_on[i])
                core_job[i].left = (core_job[i].left > elapsed) ?
                                   core_job[i].left - elapsed[15:0] : 16'd0;
        last_now = e.t;
        if (e.md == MODE_ARRIVE) begin
            placed = 0;
            t.id = e.id; t.length = e.len; t.left = e.len; t.urgency = e.pri;
            t.arrival = e.t; t.first = e.t; t.started = 1'b1;
            for (int i = 0; i < n && !placed; i++)
                if (!core_on[i]) begin
                    core_job[i] = t; core_on[i] = 1;
                    o.sched = 1; o.core = 3'(i); o.job = t.id; placed = 1;
                end
            if (!placed && (sched_mode == SCH_PSJF || sched_mode == SCH_PPRI))
                for (int i = 0; i < n && !placed; i++)
                    if (ahead_of(t, core_job[i])) begin
                        placed = 1;
                        if (ready_q.size() < QDEPTH) begin
                            enqueue_ready(core_job[i]);
                            core_job[i] = t;
                            o.sched = 1; o.core = 3'(i); o.job = t.id;
                            preempts++;
                        end else
                            o.ovf = 1;
                    end
            if (!placed) begin
                if (ready_q.size() < QDEPTH) begin
                    t.first = '0; t.started = 1'b0;
                    enqueue_ready(t);
                end else
                    o.ovf = 1;
            end
        end else if (e.md == MODE_FINISH && e.ci < n) begin
            if (core_on[e.ci]) begin
                r = core_job[e.ci];
                turn = e.t - r.arrival;
                wt = (turn >= r.length) ? turn - r.length : 32'd0;
                sum_wait += {16'd0, wt};
                sum_turn += {16'd0, turn};
                sum_resp += {16'd0, r.first - r.arrival};
                finished++;
                core_on[e.ci] = 0;
            end
            if (ready_q.size() > 0) begin
                t = ready_q.pop_front();
                if (!t.started) begin
                    t.first = e.t; t.started = 1'b1;
                end
                core_job[e.ci] = t; core_on[e.ci] = 1;
                o.sched = 1; o.core = e.ci; o.job = t.id;
            end
        end else if (e.md == MODE_EXPIRE && e.ci < n && core_on[e.ci]) begin
            r = core_job[e.ci];
            if (ready_q.size() == 0 || ahead_of(r, ready_q[0])) begin
                o.sched = 1; o.core = e.ci; o.job = r.id;
            end else begin
                t = ready_q.pop_front();
                enqueue_ready(r);
                if (!t.started) begin
                    t.first = e.t; t.started = 1'b1;
                end
                core_job[e.ci] = t;
                o.sched = 1; o.core = e.ci; o.job = t.id;
            end
        end
        if (o.ovf) overflows++;
        o.done_cnt = finished;
        o.wait_sum = sum_wait;
        o.turn_sum = sum_turn;
        o.resp_sum = sum_resp;
    endtask

    task automatic send_event(row_t e);
        outcome_t o;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        start <= 1'b1;
        mode <= e.md; job_id <= e.id; now <= e.t;
        run_length <= e.len; priority_req <= e.pri; core_index <= e.ci;
        do @(posedge clk); while (busy);
        schedule_event(e, o);
        if (e.typed) begin
            o.sched = e.sched; o.core = e.core; o.job = e.job; o.ovf = e.ovf;
        end
        pending.push_back(o);
        events_sent++;
    endtask

    task automatic drain;
        start <= 1'b0;
        do @(posedge clk); while (pending.size() != 0 || busy);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        if (idx == CFG_SCHEME) sched_mode = val[2:0];
        else core_limit = val;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        outcome_t x;
        if (rst_n && done) begin
            beats_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got job %0h",
                         $time, placed_job);
                errors++;
            end else begin
                x = pending.pop_front();
                check_field("scheduled", x.sched, scheduled);
                check_field("target_core", x.core, target_core);
                check_field("placed_job", x.job, placed_job);
                check_field("queue_overflow", x.ovf, queue_overflow);
                check_field("jobs_done", x.done_cnt, jobs_done);
                check_field("total_wait", x.wait_sum, total_wait);
                check_field("total_turnaround", x.turn_sum, total_turnaround);
                check_field("total_response", x.resp_sum, total_response);
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || done || cfg_we || !rst_n)
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic row_t ev(logic [1:0] md, logic [15:0] id, logic [31:0] t,
                                logic [15:0] len, logic [15:0] pri, logic [2:0] ci);
        row_t r;
        r = '{default: '0};
        r.md = md; r.id = id; r.t = t; r.len = len; r.pri = pri; r.ci = ci;
        return r;
    endfunction

    function automatic row_t ev_typed(row_t r, logic s, logic [2:0] c, logic [15:0] j,
                                      logic ov);
        r.typed = 1; r.sched = s; r.core = c; r.job = j; r.ovf = ov;
        return r;
    endfunction

    function automatic row_t cfg_row(logic idx, logic [3:0] val);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1; r.ci = {2'b0, idx}; r.len = {12'd0, val};
        return r;
    endfunction

    // random event, mostly sane time steps with occasional random jumps
    function automatic row_t rand_event(int arrive_pct);
        row_t r;
        int   p;
        r = '{default: '0};
        p = $urandom_range(0, 99);
        r.md = (p < arrive_pct) ? MODE_ARRIVE : (p < arrive_pct + 30) ? MODE_FINISH :
               (p < 96) ? MODE_EXPIRE : MODE_NOP;
        r.id = 16'($urandom);
        case ($urandom_range(0, 19))
            0: tnow = $urandom;
            1: tnow = tnow;
            default: tnow = tnow + $urandom_range(0, 40);
        endcase
        r.t = tnow;
        r.len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(1, 200));
        r.pri = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        r.ci = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                           : 3'($urandom_range(0, 2));
        return r;
    endfunction

    row_t directed[$];
    int   cores_list[10] = '{1, 8, 0, 15, 2, 3, 4, 1, 5, 8};

    initial begin
        row_t r;
        errors = 0; events_sent = 0; beats_seen = 0; overflows = 0; preempts = 0;
        wd_count = 0; gaps_on = 1; tnow = 32'd200;
        rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        mode = '0; job_id = '0; now = '0; run_length = 16'd1; priority_req = '0;
        core_index = '0;
        sched_mode = SCH_FCFS; core_limit = 4'd1; last_now = '0;
        sum_wait = '0; sum_turn = '0; sum_resp = '0; finished = '0;
        foreach (core_on[i]) core_on[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(ev_typed(ev(MODE_ARRIVE, 16'hFFFF, 10, 1, 0, 0), 1, 0, 16'hFFFF, 0));
        directed.push_back(ev_typed(ev(MODE_ARRIVE, 0, 20, 16'hFFFF, 16'hFFFF, 0), 0, 0, 0, 0));
        // running job arrived first, so it stays on the core
        directed.push_back(ev_typed(ev(MODE_EXPIRE, 1, 20, 1, 0, 0), 1, 0, 16'hFFFF, 0));
        directed.push_back(ev_typed(ev(MODE_FINISH, 2, 30, 1, 0, 0), 1, 0, 0, 0));
        directed.push_back(ev_typed(ev(MODE_FINISH, 3, 40, 1, 0, 7), 0, 0, 0, 0));
        directed.push_back(ev_typed(ev(MODE_NOP, 4, 50, 1, 0, 0), 0, 0, 0, 0));
        // time goes backwards
        directed.push_back(ev_typed(ev(MODE_FINISH, 5, 0, 1, 0, 0), 0, 0, 0, 0));
        directed.push_back(ev_typed(ev(MODE_EXPIRE, 6, 5, 1, 0, 0), 0, 0, 0, 0));
        directed.push_back(cfg_row(CFG_SCHEME, SCH_PSJF));
        directed.push_back(cfg_row(CFG_CORES, 4'd2));
        directed.push_back(ev_typed(ev(MODE_ARRIVE, 1, 100, 50, 3, 0), 1, 0, 1, 0));
        directed.push_back(ev_typed(ev(MODE_ARRIVE, 2, 100, 40, 3, 0), 1, 1, 2, 0));
        directed.push_back(ev_typed(ev(MODE_ARRIVE, 3, 110, 5, 3, 0), 1, 0, 3, 0));
        directed.push_back(ev_typed(ev(MODE_ARRIVE, 4, 110, 1000, 3, 0), 0, 0, 0, 0));
        directed.push_back(ev(MODE_EXPIRE, 0, 120, 1, 0, 1));
        directed.push_back(ev(MODE_FINISH, 0, 130, 1, 0, 0));
        directed.push_back(cfg_row(CFG_SCHEME, SCH_PPRI));
        directed.push_back(ev(MODE_ARRIVE, 5, 140, 7, 0, 0));
        directed.push_back(ev(MODE_ARRIVE, 6, 140, 9, 16'hFFFF, 0));
        directed.push_back(cfg_row(CFG_SCHEME, SCH_RR));
        directed.push_back(ev(MODE_EXPIRE, 0, 150, 1, 0, 0));
        directed.push_back(cfg_row(CFG_SCHEME, 4'hF));
        directed.push_back(cfg_row(CFG_CORES, 4'hF));
        directed.push_back(ev(MODE_ARRIVE, 7, 160, 3, 1, 0));
        directed.push_back(cfg_row(CFG_CORES, 4'h0));
        directed.push_back(ev(MODE_FINISH, 0, 170, 1, 0, 0));

        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                drain();
                write_reg(directed[k].ci[0], directed[k].len[3:0]);
            end else
                send_event(directed[k]);
        end

        for (int ph = 0; ph < 10; ph++) begin
            drain();
            write_reg(CFG_SCHEME, (ph < 6) ? ph[3:0] : 4'($urandom_range(0, 15)));
            write_reg(CFG_CORES, 4'(cores_list[ph]));
            gaps_on = (ph < 8);
            for (int k = 0; k < 100; k++) begin
                // a flood of arrivals fills the ready queue past its depth
                if (k == 50 && (ph == 0 || ph == 4))
                    repeat (70) begin
                        r = rand_event(100);
                        r.md = MODE_ARRIVE;
                        send_event(r);
                    end
                send_event(rand_event(($urandom_range(0, 1) == 0) ? 40 : 60));
            end
        end

        drain();
        repeat (300) @(posedge clk);
        $display("Ran %0d events over all six schemes and core counts 1 to 8;", events_sent);
        $display("saw %0d results, %0d preemptions, %0d dropped arrivals.",
                 beats_seen, preempts, overflows);
        if (errors == 0 && pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
